### rtl/core/argb_box_downsample_2x_assert.svh
// ----------------------------------------------------------------------------
// argb box downsample assertion macros
// concurrent checks with a synchronous active-high reset
// ----------------------------------------------------------------------------
`ifndef ARGB_BOX_DOWNSAMPLE_2X_ASSERT_SVH
`define ARGB_BOX_DOWNSAMPLE_2X_ASSERT_SVH

// consequent checked in the same cycle
`define ABD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abd assertion failed");

// consequent checked in the cycle after the antecedent
`define ABD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abd assertion failed");

`endif

### rtl/core/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// shared types, constants and channel arithmetic for the 2x2 box downsampler
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int DIM_DEFAULT = 4096;
  localparam int NUM_CH      = 4;
  localparam int CH_W        = 8;
  localparam int SUM_W       = CH_W + 1;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int PSUM_W      = NUM_CH * SUM_W;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  // one unit of work for the back end
  typedef struct packed {
    logic              wr;        // store pair sums into the line memory
    logic              use_line;  // average with the stored pair sums
    logic              last;      // final output pixel of the frame
    logic [PSUM_W-1:0] hsum;
  } op_t;

  // per-channel sums of two pixels, four 9-bit fields
  function automatic logic [PSUM_W-1:0] pair_sum(logic [PIX_W-1:0] a,
                                                 logic [PIX_W-1:0] b);
    logic [PSUM_W-1:0] r;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      r[c*SUM_W +: SUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
    end
    return r;
  endfunction

  // adds two packed pair sums per channel, divides by four
  function automatic logic [PIX_W-1:0] quad_mean(logic [PSUM_W-1:0] p,
                                                 logic [PSUM_W-1:0] q);
    logic [PIX_W-1:0] r;
    logic [SUM_W:0]   s;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s = {1'b0, p[c*SUM_W +: SUM_W]} + {1'b0, q[c*SUM_W +: SUM_W]};
      r[c*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return r;
  endfunction

endpackage

### rtl/core/abd_front.sv
// ----------------------------------------------------------------------------
// abd_front
// holds the frame size, tracks position, pairs columns and issues back-end ops
// ----------------------------------------------------------------------------
module abd_front import abd_pkg::*; #(
  parameter int MAX_DIM = DIM_DEFAULT,
  parameter int IDX_W   = (MAX_DIM / 2 > 1) ? $clog2(MAX_DIM / 2) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PIX_W-1:0]          src_pixel,
  output logic                      op_valid,
  input  logic                      op_ready,
  output logic [IDX_W-1:0]          op_idx,
  output op_t                       op
);

  localparam int LINE_DEPTH = (MAX_DIM / 2 > 0) ? MAX_DIM / 2 : 1;
  localparam int CNT_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [PIX_W-1:0] left_pixel;

  logic             take;
  logic             w_one, h_one;
  logic [CNT_W-1:0] x_last, y_last, ow_last, oh_last;
  logic [CNT_W-1:0] x_half, y_half;
  logic             x_end, y_end;
  logic             have_pair, in_range;

  assign w_one   = (width_eff == DIM_W'(1));
  assign h_one   = (height_eff == DIM_W'(1));
  assign x_last  = CNT_W'(width_eff - DIM_W'(1));
  assign y_last  = CNT_W'(height_eff - DIM_W'(1));
  assign ow_last = w_one ? '0 : CNT_W'((width_eff >> 1) - DIM_W'(1));
  assign oh_last = h_one ? '0 : CNT_W'((height_eff >> 1) - DIM_W'(1));
  assign x_half  = column_count >> 1;
  assign y_half  = row_count >> 1;
  assign x_end   = (column_count == x_last);
  assign y_end   = (row_count == y_last);

  assign in_ready  = op_ready;
  assign take      = in_valid && in_ready;
  assign have_pair = w_one || column_count[0];
  assign in_range  = (32'(x_half) < LINE_DEPTH);

  always_comb begin
    op.hsum     = w_one ? pair_sum(src_pixel, src_pixel) : pair_sum(left_pixel, src_pixel);
    op.last     = (x_half == ow_last) && (y_half == oh_last);
    op.wr       = 1'b0;
    op.use_line = 1'b0;
    op_valid    = 1'b0;
    op_idx      = IDX_W'(x_half & CNT_W'(LINE_DEPTH - 1));
    if (in_valid && have_pair && in_range) begin
      if (h_one) begin
        op_valid = 1'b1;
      end else if (!row_count[0]) begin
        // even row: keep pair sums unless this row is dropped
        op.wr    = 1'b1;
        op_valid = !y_end;
      end else begin
        op.use_line = 1'b1;
        op_valid    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff    <= DIM_W'(1);
      height_eff   <= DIM_W'(1);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT)) begin
      column_count <= '0;
      row_count    <= '0;
      if (cfg_index == REG_SRC_WIDTH) begin
        if (cfg_data == '0) width_eff <= DIM_W'(1);
        else if (32'(cfg_data) > MAX_DIM) width_eff <= DIM_W'(MAX_DIM);
        else width_eff <= DIM_W'(cfg_data);
      end else begin
        if (cfg_data == '0) height_eff <= DIM_W'(1);
        else if (32'(cfg_data) > MAX_DIM) height_eff <= DIM_W'(MAX_DIM);
        else height_eff <= DIM_W'(cfg_data);
      end
    end else if (take) begin
      if (x_end) begin
        column_count <= '0;
        row_count    <= y_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !w_one && !column_count[0] && !x_end) begin
      left_pixel <= src_pixel;
    end
  end

endmodule

### rtl/core/abd_queue.sv
// ----------------------------------------------------------------------------
// abd_queue
// small first-in first-out buffer between the front end and the back end
// ----------------------------------------------------------------------------
module abd_queue import abd_pkg::*; #(
  parameter int WIDTH = PSUM_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  `include "argb_box_downsample_2x_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop) count <= count + (PTR_W+1)'(1);
      else if (pop && !push) count <= count - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_data;
  end

  `ABD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= (PTR_W+1)'(DEPTH))
  `ABD_ASSERT_NOW(a_empty_ptrs, clk, rst, count == '0, wptr == rptr)
  `ABD_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, count != '0)

endmodule

### rtl/core/abd_back.sv
// ----------------------------------------------------------------------------
// abd_back
// line memory access, vertical averaging and the registered output stage
// ----------------------------------------------------------------------------
module abd_back import abd_pkg::*; #(
  parameter int LINE_DEPTH = DIM_DEFAULT / 2,
  parameter int IDX_W      = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [IDX_W-1:0] q_idx,
  input  op_t              q_op,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             frame_last
);

  `include "argb_box_downsample_2x_assert.svh"

  logic [PSUM_W-1:0] line_mem [LINE_DEPTH];
  logic [PSUM_W-1:0] line_rd;
  op_t               b_op;
  logic              b_valid;
  logic              out_load, b_free, pop;

  assign out_load = !out_valid || out_ready;
  assign b_free   = !b_valid || out_load;
  assign q_ready  = b_free;
  assign pop      = q_valid && q_ready;

  // pair sums of the even row, read back on the odd row
  always_ff @(posedge clk) begin
    if (pop && q_op.wr) line_mem[q_idx] <= q_op.hsum;
    if (pop && q_op.use_line) line_rd <= line_mem[q_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_free) b_valid <= pop && !q_op.wr;
      if (out_load) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b_op <= q_op;
    if (out_load && b_valid) begin
      out_pixel  <= quad_mean(b_op.use_line ? line_rd : b_op.hsum, b_op.hsum);
      frame_last <= b_op.last;
    end
  end

  `ABD_ASSERT_NEXT(a_store_no_result, clk, rst, pop && q_op.wr, !b_valid)
  `ABD_ASSERT_NEXT(a_stall_holds, clk, rst, b_valid && !out_load,
                   b_valid && $stable(b_op))
  `ABD_ASSERT_NEXT(a_no_phantom_out, clk, rst, !b_valid && out_load, !out_valid)

endmodule

### rtl/core/argb_box_downsample_2x.sv
// ----------------------------------------------------------------------------
// argb_box_downsample_2x
// 2x2 box-filter downsampler for a raster stream of four-channel pixels
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  input     in_valid in_ready src_pixel      in_valid && in_ready
//  output    out_valid out_ready out_pixel    out_valid && out_ready
//            frame_last
//  config    cfg_we cfg_index cfg_data        cfg_we
//
//  one source pixel per clock while the queue has room; the pixel that
//  completes a block passes the queue, line memory read and output register
//  the line memory takes one access per cycle, a read or a write, on one port
//  a four-entry queue lets the input keep going while the output stalls
//  reset clears control only; the line memory needs no clearing
// ----------------------------------------------------------------------------
module argb_box_downsample_2x import abd_pkg::*; #(
  parameter int MAX_DIM = DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     src_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel,
  output logic                 frame_last
);

  localparam int LINE_DEPTH = (MAX_DIM / 2 > 0) ? MAX_DIM / 2 : 1;
  localparam int IDX_W      = (MAX_DIM / 2 > 1) ? $clog2(MAX_DIM / 2) : 1;
  localparam int OP_W       = $bits(op_t);

  logic             f_valid, f_ready;
  logic [IDX_W-1:0] f_idx;
  op_t              f_op;
  logic             q_valid, q_ready;
  logic [IDX_W+OP_W-1:0] q_data;

  abd_front #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_pixel (src_pixel),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op_idx    (f_idx),
    .op        (f_op)
  );

  abd_queue #(
    .WIDTH (IDX_W + OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_idx, f_op}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  abd_back #(
    .LINE_DEPTH (LINE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_idx      (q_data[IDX_W+OP_W-1:OP_W]),
    .q_op       (op_t'(q_data[OP_W-1:0])),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .frame_last (frame_last)
  );

endmodule

### bench/tb_argb_box_downsample_2x.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_argb_box_downsample_2x
// self-checking bench for the 2x2 box downsampler: pixels stream in through
// a random-stall valid/ready handshake, a scoreboard predicts every averaged
// pixel and its frame-last flag, and the output side stalls at random too
// ----------------------------------------------------------------------------
module tb_argb_box_downsample_2x import abd_pkg::*;;

  localparam int LINE_DEPTH   = DIM_DEFAULT / 2;
  localparam int DRAIN_SLACK  = 8;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_PCT     = 18;

  // indexes past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } avg_pixel_t;

  class avg_scoreboard;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    int unsigned       col;
    int unsigned       row;
    logic [PIX_W-1:0]  held_left;
    logic [PSUM_W-1:0] pair_line [LINE_DEPTH];
    avg_pixel_t        expected_q [$];
    int unsigned       mismatches;

    function new();
      width_reg  = CFG_W'(1);
      height_reg = CFG_W'(1);
      col        = 0;
      row        = 0;
      held_left  = '0;
      mismatches = 0;
      foreach (pair_line[i]) pair_line[i] = '0;
    endfunction

    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > DIM_DEFAULT) return DIM_DEFAULT;
      return int'(v);
    endfunction

    function logic [PSUM_W-1:0] chan_pair(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      logic [PSUM_W-1:0] r;
      r = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        r[c*SUM_W +: SUM_W] = SUM_W'(a[c*CH_W +: CH_W]) + SUM_W'(b[c*CH_W +: CH_W]);
      end
      return r;
    endfunction

    function logic [PIX_W-1:0] chan_mean(logic [PSUM_W-1:0] p, logic [PSUM_W-1:0] q);
      logic [PIX_W-1:0] r;
      logic [SUM_W:0]   s;
      r = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        s = (SUM_W+1)'(p[c*SUM_W +: SUM_W]) + (SUM_W+1)'(q[c*SUM_W +: SUM_W]);
        r[c*CH_W +: CH_W] = CH_W'(s >> 2);
      end
      return r;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_SRC_WIDTH) width_reg = val;
      else if (idx == REG_SRC_HEIGHT) height_reg = val;
      else return;
      col = 0;
      row = 0;
    endfunction

    function void note_input(logic [PIX_W-1:0] px);
      int unsigned       w, h, x, y, ow, oh;
      logic [PSUM_W-1:0] hsum;
      bit                have_pair;
      bit                emit;
      avg_pixel_t        res;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      x = col;
      y = row;
      if (x >= w) x = w - 1;
      if (y >= h) y = h - 1;
      ow = (w == 1) ? 1 : w / 2;
      oh = (h == 1) ? 1 : h / 2;
      have_pair = 0;
      emit = 0;
      hsum = '0;
      res = '0;
      if (w == 1) begin
        hsum = chan_pair(px, px);
        have_pair = 1;
      end else if (x % 2 == 0) begin
        if (x + 1 < w) held_left = px;
      end else begin
        hsum = chan_pair(held_left, px);
        have_pair = 1;
      end
      if (have_pair && x / 2 < LINE_DEPTH) begin
        if (h == 1) begin
          res.pixel = chan_mean(hsum, hsum);
          emit = 1;
        end else if (y % 2 == 0) begin
          // even row: park the pair sum for the row below
          if (y + 1 < h) pair_line[x / 2] = hsum;
        end else begin
          res.pixel = chan_mean(pair_line[x / 2], hsum);
          emit = 1;
        end
        if (emit) begin
          res.last = (x / 2 == ow - 1) && (y / 2 == oh - 1);
          expected_q.push_back(res);
        end
      end
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [PIX_W-1:0] px, logic last);
      avg_pixel_t exp_px;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("output pixel %h with nothing pending", px));
        return;
      end
      exp_px = expected_q.pop_front();
      if (px !== exp_px.pixel)
        report_mismatch($sformatf("out_pixel %h, want %h", px, exp_px.pixel));
      if (last !== exp_px.last)
        report_mismatch($sformatf("frame_last %b, want %b (pixel %h)",
                                  last, exp_px.last, exp_px.pixel));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     src_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic                 frame_last;

  bit                   steady = 1'b0;
  avg_scoreboard        sb = new();

  argb_box_downsample_2x dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_pixel  (src_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .frame_last (frame_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_pixel, frame_last);
  end

  task send_pixel(logic [PIX_W-1:0] px);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    src_pixel <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_input(px);
  endtask

  // input held off until every pending pixel is out and the pipe is quiet
  task drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.note_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain_results();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
  endtask

  task send_frame(int unsigned count, bit may_pause);
    for (int unsigned i = 0; i < count; i++) begin
      if (may_pause && i == count / 2 && $urandom_range(0, 99) < 10) drain_results();
      send_pixel($urandom());
    end
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      frame;
    int unsigned      count;
    int unsigned      sel;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size is 1x1: every pixel comes straight back
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);

    set_size(CFG_W'(2), CFG_W'(2));
    send_pixel(32'hff00_ff00);
    send_pixel(32'h00ff_00ff);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0103_0507);

    // zero size acts as one
    set_size(CFG_W'(0), CFG_W'(0));
    send_pixel(32'h1234_5678);

    // odd width and height: last column and row dropped
    set_size(CFG_W'(3), CFG_W'(3));
    send_pixel(32'haaaa_aaaa);
    send_pixel(32'h5555_5555);
    send_pixel(32'hdead_beef);
    send_pixel(32'h5555_5555);
    send_pixel(32'haaaa_aaaa);
    send_pixel(32'h0f0f_0f0f);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hffff_ffff);

    // spare indexes written mid-frame must not restart it
    set_size(CFG_W'(4), CFG_W'(2));
    send_pixel(32'hffff_ffff);
    send_pixel(32'hfefe_fefe);
    send_pixel(32'h0101_0101);
    drain_results();
    write_reg(REG_SPARE_A, CFG_W'(8191));
    write_reg(REG_SPARE_B, CFG_W'(0));
    send_pixel(32'h0000_0000);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7f7f_7f7f);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0001);

    // oversized registers clamp to the maximum; no idling on either side
    steady = 1'b1;
    set_size(CFG_W'(8191), CFG_W'(1));
    send_frame(64, 1'b0);
    set_size(CFG_W'(1), CFG_W'(8191));
    send_frame(64, 1'b0);
    steady = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        w_val = CFG_W'($urandom_range(DIM_DEFAULT + 1, 8191));
      end else if (sel < 6) begin
        w_val = '0;
      end else if (sel < 14) begin
        w_val = CFG_W'($urandom_range(13, 70));
      end else begin
        w_val = CFG_W'($urandom_range(1, 12));
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        h_val = CFG_W'($urandom_range(DIM_DEFAULT - 2, 8191));
      end else if (sel < 8) begin
        h_val = '0;
      end else if (w_val > CFG_W'(12)) begin
        h_val = CFG_W'($urandom_range(1, 3));
      end else begin
        h_val = CFG_W'($urandom_range(1, 8));
      end

      drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // only one register: still restarts the frame
        if ($urandom_range(0, 1) == 1) write_reg(REG_SRC_WIDTH, w_val);
        else write_reg(REG_SRC_HEIGHT, h_val);
      end else if (sel < 18) begin
        // ignored write, frame carries on where it stood
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_W'($urandom()));
      end else if (sel < 24) begin
        // no write at all
      end else begin
        write_reg(REG_SRC_WIDTH, w_val);
        write_reg(REG_SRC_HEIGHT, h_val);
      end

      frame = sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
      if (frame > 600 || $urandom_range(0, 99) < 20) begin
        // broken frame, cut short by the next write
        count = $urandom_range(1, (frame < 40) ? frame : 40);
      end else begin
        count = frame * $urandom_range(1, 2);
      end
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      send_frame(count, 1'b1);
      sent += count;
    end

    in_valid <= 1'b0;
    for (int i = 0; i < 4000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d output pixels never arrived", sb.pending()));

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/abd_pkg.sv
rtl/core/abd_front.sv
rtl/core/abd_queue.sv
rtl/core/abd_back.sv
rtl/core/argb_box_downsample_2x.sv
bench/tb_argb_box_downsample_2x.sv
